// File: hdl/ttyld_pkg.sv
// shared types and constants of the terminal line discipline
`default_nettype none
package ttyld_pkg;

   // ring sizes
   localparam int INPUT_DEPTH = 4096;
   localparam int LINE_DEPTH  = 1024;

   localparam int RAW_AW      = $clog2(INPUT_DEPTH);
   localparam int RAW_FILL_W  = $clog2(INPUT_DEPTH + 1);
   localparam int LINE_AW     = $clog2(LINE_DEPTH);
   // the line ring never holds more than LINE_DEPTH-1 bytes
   localparam int LINE_FILL_W = LINE_AW;

   localparam int MAX_RES   = 3;
   localparam int RES_IDX_W = 2;
   localparam int CSR_IDX_W = 2;

   // character codes
   localparam logic [7:0] CH_INTR  = 8'h03;
   localparam logic [7:0] CH_SUSP  = 8'h1A;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [1:0] {
      CMD_RX   = 2'd0,
      CMD_TX   = 2'd1,
      CMD_READ = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_TX    = 3'd0,
      KIND_DATA  = 3'd1,
      KIND_EMPTY = 3'd2,
      KIND_INTR  = 3'd3,
      KIND_SUSP  = 3'd4
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CANONICAL = 2'd0,
      REG_ECHO      = 2'd1,
      REG_SIGNAL    = 2'd2,
      REG_MAP_NL    = 2'd3
   } reg_type;

   // controller to datapath
   typedef struct packed {
      logic                 load;
      logic [RES_IDX_W-1:0] idx;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [RES_IDX_W-1:0] load_count;
      logic [RES_IDX_W-1:0] res_count;
   } dp_status_type;

endpackage
`default_nettype wire

// File: hdl/ttyld_if.sv
// channel interfaces: request, response and register write
`default_nettype none
interface ttyld_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] data_byte;
   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface ttyld_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] byte_out;
   logic       line_complete;
   logic       last;
   modport source (output valid, output kind, output byte_out, output line_complete,
                   output last, input ready);
   modport sink (input valid, input kind, input byte_out, input line_complete,
                 input last, output ready);
endinterface

interface ttyld_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ttyld_pkg::CSR_IDX_W-1:0] index;
   logic                            data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/ttyld_ram.sv
// generic single write port ram with registered read
`default_nettype none
module ttyld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hdl/ttyld_datapath.sv
// datapath: mode registers, ring pointers, byte stores and result words
`default_nettype none
module ttyld_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ttyld_pkg::ctrl_cmd_type         ctrl,
   output ttyld_pkg::dp_status_type             status,
   input  wire logic [1:0]                      req_cmd,
   input  wire logic [7:0]                      req_data_byte,
   input  wire logic                            csr_we,
   input  wire logic [ttyld_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic                            csr_data,
   output logic      [2:0]                      rsp_kind,
   output logic      [7:0]                      rsp_byte_out,
   output logic                                 rsp_line_complete,
   output logic                                 rsp_last
);

   localparam int RAW_AW      = ttyld_pkg::RAW_AW;
   localparam int RAW_FILL_W  = ttyld_pkg::RAW_FILL_W;
   localparam int LINE_AW     = ttyld_pkg::LINE_AW;
   localparam int LINE_FILL_W = ttyld_pkg::LINE_FILL_W;
   localparam int RES_IDX_W   = ttyld_pkg::RES_IDX_W;
   localparam int MAX_RES     = ttyld_pkg::MAX_RES;

   // mode registers
   logic canon_ff, echo_ff, sig_ff, map_ff;

   // ring state
   logic [RAW_AW-1:0]      raw_wp_ff, raw_wp_in;
   logic [RAW_AW-1:0]      raw_rp_ff, raw_rp_in;
   logic [RAW_FILL_W-1:0]  raw_fill_ff, raw_fill_in;
   logic [LINE_AW-1:0]     line_start_ff, line_start_in;
   logic [LINE_FILL_W-1:0] line_fill_ff, line_fill_in;
   logic                   flag_ff, flag_in;

   // result words of the current item
   ttyld_pkg::kind_type    res_kind_ff [MAX_RES];
   ttyld_pkg::kind_type    res_kind_in [MAX_RES];
   logic [7:0]             res_byte_ff [MAX_RES];
   logic [7:0]             res_byte_in [MAX_RES];
   logic [RES_IDX_W-1:0]   res_count_ff, res_count_in;
   logic                   sel_line_ff, sel_line_in;

   // store ports
   logic                   line_we, line_re, raw_we, raw_re;
   logic [7:0]             line_wdata, line_rdata, raw_rdata;
   logic [LINE_AW:0]       line_sum;
   logic [LINE_AW-1:0]     line_waddr;

   ttyld_pkg::cmd_type     cmd;
   logic [7:0]             c;
   logic                   is_erase, is_eol, line_room;

   assign cmd       = ttyld_pkg::cmd_type'(req_cmd);
   assign c         = req_data_byte;
   assign is_erase  = (c == ttyld_pkg::CH_BS) || (c == ttyld_pkg::CH_DEL);
   assign is_eol    = (c == ttyld_pkg::CH_LF) || (c == ttyld_pkg::CH_CR);
   assign line_room = line_fill_ff < LINE_FILL_W'(ttyld_pkg::LINE_DEPTH - 1);

   // write position of the line ring: start plus fill, wrapped once
   always_comb begin
      line_sum = {1'b0, line_start_ff} + (LINE_AW + 1)'(line_fill_ff);
      if (line_sum >= (LINE_AW + 1)'(ttyld_pkg::LINE_DEPTH)) begin
         line_sum = line_sum - (LINE_AW + 1)'(ttyld_pkg::LINE_DEPTH);
      end
      line_waddr = line_sum[LINE_AW-1:0];
   end

   always_comb begin
      raw_wp_in     = raw_wp_ff;
      raw_rp_in     = raw_rp_ff;
      raw_fill_in   = raw_fill_ff;
      line_start_in = line_start_ff;
      line_fill_in  = line_fill_ff;
      flag_in       = flag_ff;
      sel_line_in   = canon_ff;
      line_we       = 1'b0;
      line_re       = 1'b0;
      raw_we        = 1'b0;
      raw_re        = 1'b0;
      line_wdata    = c;
      res_count_in  = '0;
      for (int i = 0; i < MAX_RES; i++) begin
         res_kind_in[i] = ttyld_pkg::KIND_TX;
         res_byte_in[i] = 8'h00;
      end
      unique case (cmd)
         ttyld_pkg::CMD_RX: begin
            if (canon_ff && is_erase) begin
               if (line_fill_ff != '0) begin
                  line_fill_in = line_fill_ff - LINE_FILL_W'(1);
                  if (echo_ff) begin
                     res_byte_in[0] = ttyld_pkg::CH_BS;
                     res_byte_in[1] = ttyld_pkg::CH_SPACE;
                     res_byte_in[2] = ttyld_pkg::CH_BS;
                     res_count_in   = RES_IDX_W'(3);
                  end
               end
            end else if (canon_ff && is_eol) begin
               if (line_room) begin
                  line_we      = 1'b1;
                  line_wdata   = ttyld_pkg::CH_LF;
                  line_fill_in = line_fill_ff + LINE_FILL_W'(1);
                  flag_in      = 1'b1;
                  if (echo_ff) begin
                     if (map_ff) begin
                        res_byte_in[0] = ttyld_pkg::CH_CR;
                        res_byte_in[1] = ttyld_pkg::CH_LF;
                        res_count_in   = RES_IDX_W'(2);
                     end else begin
                        res_byte_in[0] = ttyld_pkg::CH_LF;
                        res_count_in   = RES_IDX_W'(1);
                     end
                  end
               end
            end else begin
               if (canon_ff) begin
                  if (line_room) begin
                     line_we      = 1'b1;
                     line_fill_in = line_fill_ff + LINE_FILL_W'(1);
                     if (echo_ff) begin
                        res_byte_in[0] = c;
                        res_count_in   = RES_IDX_W'(1);
                     end
                  end
               end else if (raw_fill_ff < RAW_FILL_W'(ttyld_pkg::INPUT_DEPTH)) begin
                  raw_we      = 1'b1;
                  raw_fill_in = raw_fill_ff + RAW_FILL_W'(1);
                  raw_wp_in   = (raw_wp_ff == RAW_AW'(ttyld_pkg::INPUT_DEPTH - 1)) ?
                                '0 : raw_wp_ff + RAW_AW'(1);
               end
               // signal word follows any echo
               if (sig_ff && (c == ttyld_pkg::CH_INTR || c == ttyld_pkg::CH_SUSP)) begin
                  res_kind_in[res_count_in] = (c == ttyld_pkg::CH_INTR) ?
                                              ttyld_pkg::KIND_INTR : ttyld_pkg::KIND_SUSP;
                  res_count_in = res_count_in + RES_IDX_W'(1);
               end
            end
         end
         ttyld_pkg::CMD_TX: begin
            if (c == ttyld_pkg::CH_LF && map_ff) begin
               res_byte_in[0] = ttyld_pkg::CH_CR;
               res_byte_in[1] = c;
               res_count_in   = RES_IDX_W'(2);
            end else begin
               res_byte_in[0] = c;
               res_count_in   = RES_IDX_W'(1);
            end
         end
         ttyld_pkg::CMD_READ: begin
            res_count_in   = RES_IDX_W'(1);
            res_kind_in[0] = ttyld_pkg::KIND_EMPTY;
            if (canon_ff) begin
               if (flag_ff && line_fill_ff == '0) begin
                  flag_in = 1'b0;
               end else if (flag_ff) begin
                  line_re        = 1'b1;
                  res_kind_in[0] = ttyld_pkg::KIND_DATA;
                  line_fill_in   = line_fill_ff - LINE_FILL_W'(1);
                  line_start_in  = (line_start_ff == LINE_AW'(ttyld_pkg::LINE_DEPTH - 1)) ?
                                   '0 : line_start_ff + LINE_AW'(1);
                  if (line_fill_ff == LINE_FILL_W'(1)) begin
                     flag_in = 1'b0;
                  end
               end
            end else if (raw_fill_ff != '0) begin
               raw_re         = 1'b1;
               res_kind_in[0] = ttyld_pkg::KIND_DATA;
               raw_fill_in    = raw_fill_ff - RAW_FILL_W'(1);
               raw_rp_in      = (raw_rp_ff == RAW_AW'(ttyld_pkg::INPUT_DEPTH - 1)) ?
                                '0 : raw_rp_ff + RAW_AW'(1);
            end
         end
         ttyld_pkg::CMD_NONE: begin
            res_count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         canon_ff      <= 1'b1;
         echo_ff       <= 1'b1;
         sig_ff        <= 1'b1;
         map_ff        <= 1'b1;
         raw_wp_ff     <= '0;
         raw_rp_ff     <= '0;
         raw_fill_ff   <= '0;
         line_start_ff <= '0;
         line_fill_ff  <= '0;
         flag_ff       <= 1'b0;
         res_count_ff  <= '0;
      end else begin
         if (csr_we) begin
            unique case (ttyld_pkg::reg_type'(csr_index))
               ttyld_pkg::REG_CANONICAL: canon_ff <= csr_data;
               ttyld_pkg::REG_ECHO:      echo_ff  <= csr_data;
               ttyld_pkg::REG_SIGNAL:    sig_ff   <= csr_data;
               ttyld_pkg::REG_MAP_NL:    map_ff   <= csr_data;
            endcase
         end
         if (ctrl.load) begin
            raw_wp_ff     <= raw_wp_in;
            raw_rp_ff     <= raw_rp_in;
            raw_fill_ff   <= raw_fill_in;
            line_start_ff <= line_start_in;
            line_fill_ff  <= line_fill_in;
            flag_ff       <= flag_in;
            res_count_ff  <= res_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         res_kind_ff <= res_kind_in;
         res_byte_ff <= res_byte_in;
         sel_line_ff <= sel_line_in;
      end
   end

   ttyld_ram #(
      .WIDTH(8),
      .DEPTH(ttyld_pkg::LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ctrl.load && line_we),
      .wr_addr (line_waddr),
      .wr_data (line_wdata),
      .rd_en   (ctrl.load && line_re),
      .rd_addr (line_start_ff),
      .rd_data (line_rdata)
   );

   ttyld_ram #(
      .WIDTH(8),
      .DEPTH(ttyld_pkg::INPUT_DEPTH)
   ) u_raw_ram (
      .clock   (clock),
      .wr_en   (ctrl.load && raw_we),
      .wr_addr (raw_wp_ff),
      .wr_data (c),
      .rd_en   (ctrl.load && raw_re),
      .rd_addr (raw_rp_ff),
      .rd_data (raw_rdata)
   );

   assign status.load_count = res_count_in;
   assign status.res_count  = res_count_ff;

   // read data comes straight from the store's output register
   always_comb begin
      rsp_kind     = res_kind_ff[ctrl.idx];
      rsp_byte_out = res_byte_ff[ctrl.idx];
      if (res_kind_ff[ctrl.idx] == ttyld_pkg::KIND_DATA) begin
         rsp_byte_out = sel_line_ff ? line_rdata : raw_rdata;
      end
   end

   assign rsp_line_complete = flag_ff;
   assign rsp_last          = (ctrl.idx == res_count_ff - RES_IDX_W'(1));

endmodule
`default_nettype wire

// File: hdl/ttyld_ctrl.sv
// controller: takes one word at a time and steps through its results
`default_nettype none
module ttyld_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire ttyld_pkg::dp_status_type  status,
   output ttyld_pkg::ctrl_cmd_type        ctrl
);

   localparam int RES_IDX_W = ttyld_pkg::RES_IDX_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [RES_IDX_W-1:0] idx_ff, idx_in;
   logic                 load, final_taken;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = (state_ff == ST_EMIT);
   assign load        = req_valid && req_ready;
   assign final_taken = rsp_valid && rsp_ready &&
                        (idx_ff == status.res_count - RES_IDX_W'(1));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (load && status.load_count != '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (final_taken) begin
               state_in = ST_IDLE;
            end else if (rsp_ready) begin
               idx_in = idx_ff + RES_IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign ctrl.load = load;
   assign ctrl.idx  = idx_ff;

endmodule
`default_nettype wire

// File: hdl/tty_line_discipline.sv
// top level of the terminal line discipline
// an item is taken when valid and ready meet; its n results (0 to 3) follow one per cycle
// from the next cycle while the sink is ready, and the next item is taken once the last result
// word is taken; an item with no result leaves the block idle and ready for the next item
// reset clears pointers, fill counts and the line flag and sets all four mode registers to 1
// the byte stores are not cleared; register writes are always taken
`default_nettype none
module tty_line_discipline (
   input  wire logic clock,
   input  wire logic reset,
   ttyld_req_if.sink   req_chan,
   ttyld_rsp_if.source rsp_chan,
   ttyld_csr_if.sink   csr_chan
);

   ttyld_pkg::ctrl_cmd_type  ctrl;
   ttyld_pkg::dp_status_type status;

   assign csr_chan.ready = 1'b1;

   ttyld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   ttyld_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .status            (status),
      .req_cmd           (req_chan.cmd),
      .req_data_byte     (req_chan.data_byte),
      .csr_we            (csr_chan.valid && csr_chan.ready),
      .csr_index         (csr_chan.index),
      .csr_data          (csr_chan.data),
      .rsp_kind          (rsp_chan.kind),
      .rsp_byte_out      (rsp_chan.byte_out),
      .rsp_line_complete (rsp_chan.line_complete),
      .rsp_last          (rsp_chan.last)
   );

`ifndef SYNTHESIS
   a_no_take_while_emitting: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.valid && req_chan.ready && rsp_chan.valid))
      else $error("word taken while results pending");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last) |=> !rsp_chan.valid)
      else $error("result after final word");

   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.kind == ttyld_pkg::KIND_EMPTY ||
       rsp_chan.kind == ttyld_pkg::KIND_INTR || rsp_chan.kind == ttyld_pkg::KIND_SUSP))
      |-> (rsp_chan.byte_out == 8'h00))
      else $error("non-zero byte on status result");
`endif

endmodule
`default_nettype wire

// File: dv/tb_tty_line_discipline.sv
// self-checking testbench of the terminal line discipline: table walk and random lines
`timescale 1ns / 1ps
module tb_tty_line_discipline;

   localparam int PERIOD       = 12;
   localparam int RESET_CYCLES = 11;
   localparam int SETTLE       = 4;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int END_WAIT     = 5000;
   localparam int MAX_REPORTS  = 100;
   localparam int RAND_PHASES  = 6;
   localparam int PHASE_ITEMS  = 70;
   localparam int SCRIPT_LEN   = 25;

   typedef struct packed {
      ttyld_pkg::kind_type kind;
      logic [7:0]          byte_out;
      logic                line_complete;
      logic                last;
   } tty_word_type;

   typedef struct packed {
      ttyld_pkg::cmd_type  cmd;
      logic [7:0]          data;
      logic                typed;
      logic                one_word;
      ttyld_pkg::kind_type kind;
      logic [7:0]          byte_out;
      logic                line_complete;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   ttyld_req_if req_if();
   ttyld_rsp_if rsp_if();
   ttyld_csr_if csr_if();

   tty_line_discipline i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #(PERIOD / 2) clock = ~clock;

   // mirror of the block state
   logic [7:0] raw_ring [ttyld_pkg::INPUT_DEPTH];
   logic [7:0] line_ring [ttyld_pkg::LINE_DEPTH];
   int         raw_wr, raw_rd, raw_cnt;
   int         line_rd, line_cnt;
   logic       line_flag_on;
   logic       canon_on, echo_on, sig_on, map_nl_on;

   tty_word_type step_words [ttyld_pkg::MAX_RES];
   int           word_n;
   tty_word_type out_words_due [$];

   stim_row_type row_now;
   stim_row_type script [SCRIPT_LEN];
   int           fails;
   int           cycle_count;
   logic         req_gaps, rsp_gaps, hold_off;
   int           rsp_gap_left;

   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 2) != 0) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 5))
         0: return ttyld_pkg::CH_INTR;
         1: return ttyld_pkg::CH_SUSP;
         2: return ttyld_pkg::CH_BS;
         3: return ttyld_pkg::CH_DEL;
         4: return ttyld_pkg::CH_LF;
         default: return ttyld_pkg::CH_CR;
      endcase
   endfunction

   // any byte that is not an edit or line-end character
   function automatic logic [7:0] line_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == ttyld_pkg::CH_BS || b == ttyld_pkg::CH_DEL ||
             b == ttyld_pkg::CH_LF || b == ttyld_pkg::CH_CR);
      return b;
   endfunction

   function automatic stim_row_type make_row(input ttyld_pkg::cmd_type cmd,
                                             input logic [7:0] data,
                                             input logic typed, input logic one_word,
                                             input ttyld_pkg::kind_type kind,
                                             input logic [7:0] b, input logic lc);
      stim_row_type r;
      r.cmd           = cmd;
      r.data          = data;
      r.typed         = typed;
      r.one_word      = one_word;
      r.kind          = kind;
      r.byte_out      = b;
      r.line_complete = lc;
      return r;
   endfunction

   function automatic stim_row_type plain(input ttyld_pkg::cmd_type cmd,
                                          input logic [7:0] data);
      return make_row(cmd, data, 1'b0, 1'b0, ttyld_pkg::KIND_TX, 8'h00, 1'b0);
   endfunction

   function automatic void add_word(input ttyld_pkg::kind_type k, input logic [7:0] b);
      if (word_n < ttyld_pkg::MAX_RES) begin
         step_words[word_n].kind          = k;
         step_words[word_n].byte_out      = b;
         step_words[word_n].line_complete = 1'b0;
         step_words[word_n].last          = 1'b0;
         word_n++;
      end
   endfunction

   function automatic void send_char(input logic [7:0] c);
      if (c == ttyld_pkg::CH_LF && map_nl_on) add_word(ttyld_pkg::KIND_TX, ttyld_pkg::CH_CR);
      add_word(ttyld_pkg::KIND_TX, c);
   endfunction

   // works out the words one item causes and advances the mirrored state
   function automatic void discipline_step(input ttyld_pkg::cmd_type cmd, input logic [7:0] c);
      logic [7:0] b;
      word_n = 0;
      case (cmd)
         ttyld_pkg::CMD_RX: begin
            if (canon_on && (c == ttyld_pkg::CH_BS || c == ttyld_pkg::CH_DEL)) begin
               // erase may remove a stored line end and never signals
               if (line_cnt > 0) begin
                  line_cnt--;
                  if (echo_on) begin
                     add_word(ttyld_pkg::KIND_TX, ttyld_pkg::CH_BS);
                     add_word(ttyld_pkg::KIND_TX, ttyld_pkg::CH_SPACE);
                     add_word(ttyld_pkg::KIND_TX, ttyld_pkg::CH_BS);
                  end
               end
            end else begin
               if (canon_on && (c == ttyld_pkg::CH_LF || c == ttyld_pkg::CH_CR)) begin
                  if (line_cnt < ttyld_pkg::LINE_DEPTH - 1) begin
                     line_ring[(line_rd + line_cnt) % ttyld_pkg::LINE_DEPTH] = ttyld_pkg::CH_LF;
                     line_cnt++;
                     line_flag_on = 1'b1;
                     if (echo_on) send_char(ttyld_pkg::CH_LF);
                  end
               end else if (canon_on) begin
                  if (line_cnt < ttyld_pkg::LINE_DEPTH - 1) begin
                     line_ring[(line_rd + line_cnt) % ttyld_pkg::LINE_DEPTH] = c;
                     line_cnt++;
                     if (echo_on) send_char(c);
                  end
               end else if (raw_cnt < ttyld_pkg::INPUT_DEPTH) begin
                  raw_ring[raw_wr] = c;
                  raw_wr = (raw_wr + 1) % ttyld_pkg::INPUT_DEPTH;
                  raw_cnt++;
               end
               // signals are raised even when the byte was dropped
               if (sig_on && c == ttyld_pkg::CH_INTR)
                  add_word(ttyld_pkg::KIND_INTR, 8'h00);
               else if (sig_on && c == ttyld_pkg::CH_SUSP)
                  add_word(ttyld_pkg::KIND_SUSP, 8'h00);
            end
         end
         ttyld_pkg::CMD_TX: send_char(c);
         ttyld_pkg::CMD_READ: begin
            if (canon_on) begin
               if (!line_flag_on) begin
                  add_word(ttyld_pkg::KIND_EMPTY, 8'h00);
               end else if (line_cnt == 0) begin
                  line_flag_on = 1'b0;
                  add_word(ttyld_pkg::KIND_EMPTY, 8'h00);
               end else begin
                  b = line_ring[line_rd];
                  line_rd = (line_rd + 1) % ttyld_pkg::LINE_DEPTH;
                  line_cnt--;
                  if (line_cnt == 0) line_flag_on = 1'b0;
                  add_word(ttyld_pkg::KIND_DATA, b);
               end
            end else if (raw_cnt == 0) begin
               add_word(ttyld_pkg::KIND_EMPTY, 8'h00);
            end else begin
               b = raw_ring[raw_rd];
               raw_rd = (raw_rd + 1) % ttyld_pkg::INPUT_DEPTH;
               raw_cnt--;
               add_word(ttyld_pkg::KIND_DATA, b);
            end
         end
         default: ;
      endcase
   endfunction

   // result check, register mirror and prediction, all on the rising edge
   always @(posedge clock) begin
      tty_word_type want;
      tty_word_type w;
      if (reset) begin
         raw_wr       = 0;
         raw_rd       = 0;
         raw_cnt      = 0;
         line_rd      = 0;
         line_cnt     = 0;
         line_flag_on = 1'b0;
         canon_on     = 1'b1;
         echo_on      = 1'b1;
         sig_on       = 1'b1;
         map_nl_on    = 1'b1;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (out_words_due.size() == 0) begin
               fails++;
               if (fails <= MAX_REPORTS)
                  $display("%0t: unexpected word: expected none, got kind %0d byte %02h",
                           $time, rsp_if.kind, rsp_if.byte_out);
            end else begin
               want = out_words_due.pop_front();
               if (rsp_if.kind !== want.kind || rsp_if.byte_out !== want.byte_out ||
                   rsp_if.line_complete !== want.line_complete || rsp_if.last !== want.last)
               begin
                  fails++;
                  // keep the log short when the block is badly broken
                  if (fails <= MAX_REPORTS)
                     $display("%0t: mismatch: expected kind %0d byte %02h line %0b last %0b, got kind %0d byte %02h line %0b last %0b",
                              $time, want.kind, want.byte_out, want.line_complete, want.last,
                              rsp_if.kind, rsp_if.byte_out, rsp_if.line_complete, rsp_if.last);
               end
            end
         end
         if (csr_if.valid && csr_if.ready) begin
            case (ttyld_pkg::reg_type'(csr_if.index))
               ttyld_pkg::REG_CANONICAL: canon_on  = csr_if.data;
               ttyld_pkg::REG_ECHO:      echo_on   = csr_if.data;
               ttyld_pkg::REG_SIGNAL:    sig_on    = csr_if.data;
               ttyld_pkg::REG_MAP_NL:    map_nl_on = csr_if.data;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            discipline_step(ttyld_pkg::cmd_type'(req_if.cmd), req_if.data_byte);
            if (row_now.typed) begin
               if (row_now.one_word) begin
                  w.kind          = row_now.kind;
                  w.byte_out      = row_now.byte_out;
                  w.line_complete = row_now.line_complete;
                  w.last          = 1'b1;
                  out_words_due.push_back(w);
               end
            end else begin
               for (int k = 0; k < word_n; k++) begin
                  w               = step_words[k];
                  w.line_complete = line_flag_on;
                  w.last          = (k == word_n - 1);
                  out_words_due.push_back(w);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // response side: random gaps, or one long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      rsp_gap_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off = 1'b0;
         end else if (!rsp_gaps) begin
            rsp_if.ready <= 1'b1;
         end else if (rsp_gap_left > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_gap_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 4) == 0) rsp_gap_left = pick_gap();
         end
      end
   end

   // returns at the rising edge where the word is taken; valid stays up for a follow-on
   task automatic send_word(input stim_row_type r);
      int gap;
      gap = 0;
      if (req_gaps && $urandom_range(0, 3) == 0) gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      row_now           = r;
      req_if.valid     <= 1'b1;
      req_if.cmd       <= r.cmd;
      req_if.data_byte <= r.data;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (out_words_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input ttyld_pkg::reg_type idx, input logic val);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // registers change only with the block idle
   task automatic apply_settings(input logic canon, input logic echo, input logic sig,
                                 input logic map_nl);
      hold_until_drained();
      repeat (SETTLE) @(negedge clock);
      write_reg(ttyld_pkg::REG_CANONICAL, canon);
      write_reg(ttyld_pkg::REG_ECHO, echo);
      write_reg(ttyld_pkg::REG_SIGNAL, sig);
      write_reg(ttyld_pkg::REG_MAP_NL, map_nl);
   endtask

   initial begin
      int         done;
      int         len;
      int         waited;
      int         pick;
      logic [7:0] b;
      logic       drained;

      fails            = 0;
      cycle_count      = 0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.cmd       = ttyld_pkg::CMD_RX;
      req_if.data_byte = 8'h00;
      csr_if.valid     = 1'b0;
      csr_if.index     = ttyld_pkg::REG_CANONICAL;
      csr_if.data      = 1'b0;
      req_gaps         = 1'b1;
      rsp_gaps         = 1'b1;
      hold_off         = 1'b0;
      drained          = 1'b0;
      row_now          = plain(ttyld_pkg::CMD_NONE, 8'h00);

      script[0]  = make_row(ttyld_pkg::CMD_READ, 8'h00, 1, 1, ttyld_pkg::KIND_EMPTY, 8'h00, 0);
      script[1]  = make_row(ttyld_pkg::CMD_NONE, 8'hFF, 1, 0, ttyld_pkg::KIND_TX, 8'h00, 0);
      script[2]  = make_row(ttyld_pkg::CMD_TX, 8'hFF, 1, 1, ttyld_pkg::KIND_TX, 8'hFF, 0);
      script[3]  = make_row(ttyld_pkg::CMD_TX, 8'h00, 1, 1, ttyld_pkg::KIND_TX, 8'h00, 0);
      script[4]  = plain(ttyld_pkg::CMD_TX, ttyld_pkg::CH_LF);
      script[5]  = plain(ttyld_pkg::CMD_RX, 8'h61);
      script[6]  = plain(ttyld_pkg::CMD_RX, ttyld_pkg::CH_BS);
      script[7]  = plain(ttyld_pkg::CMD_RX, ttyld_pkg::CH_DEL);
      script[8]  = plain(ttyld_pkg::CMD_RX, ttyld_pkg::CH_INTR);
      script[9]  = plain(ttyld_pkg::CMD_RX, ttyld_pkg::CH_SUSP);
      script[10] = plain(ttyld_pkg::CMD_RX, 8'hFF);
      script[11] = plain(ttyld_pkg::CMD_RX, 8'h00);
      script[12] = plain(ttyld_pkg::CMD_RX, ttyld_pkg::CH_CR);
      script[13] = plain(ttyld_pkg::CMD_READ, 8'h00);
      script[14] = plain(ttyld_pkg::CMD_READ, 8'hFF);
      script[15] = plain(ttyld_pkg::CMD_READ, 8'h00);
      script[16] = plain(ttyld_pkg::CMD_READ, 8'h00);
      script[17] = plain(ttyld_pkg::CMD_READ, 8'h00);
      script[18] = make_row(ttyld_pkg::CMD_READ, 8'h00, 1, 1, ttyld_pkg::KIND_EMPTY, 8'h00, 0);
      script[19] = plain(ttyld_pkg::CMD_RX, ttyld_pkg::CH_LF);
      // erasing the line end leaves the line flag set with nothing behind it
      script[20] = plain(ttyld_pkg::CMD_RX, ttyld_pkg::CH_DEL);
      script[21] = plain(ttyld_pkg::CMD_READ, 8'h00);
      script[22] = make_row(ttyld_pkg::CMD_NONE, 8'h00, 1, 0, ttyld_pkg::KIND_TX, 8'h00, 0);
      script[23] = make_row(ttyld_pkg::CMD_READ, 8'h00, 1, 1, ttyld_pkg::KIND_EMPTY, 8'h00, 0);
      script[24] = plain(ttyld_pkg::CMD_TX, ttyld_pkg::CH_CR);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < SCRIPT_LEN; i++) send_word(script[i]);

      for (int p = 0; p < RAND_PHASES; p++) begin
         if (p == 0)
            apply_settings(1'b0, 1'b0, 1'b0, 1'b0);
         else if (p == 1)
            apply_settings(1'b1, 1'b1, 1'b1, 1'b1);
         else
            apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         if (p == 3) hold_off = 1'b1;
         done = 0;
         while (done < PHASE_ITEMS) begin
            if (p == 2 && done >= 30 && !drained) begin
               hold_until_drained();
               drained = 1'b1;
            end
            if ($urandom_range(0, 2) != 0) begin
               // a typed line with the odd erase, its line end, then read it back
               len = $urandom_range(1, 8);
               for (int k = 0; k < len; k++) begin
                  if ($urandom_range(0, 5) == 0)
                     b = $urandom_range(0, 1) ? ttyld_pkg::CH_BS : ttyld_pkg::CH_DEL;
                  else
                     b = line_byte();
                  send_word(plain(ttyld_pkg::CMD_RX, b));
               end
               send_word(plain(ttyld_pkg::CMD_RX,
                               $urandom_range(0, 1) ? ttyld_pkg::CH_CR : ttyld_pkg::CH_LF));
               repeat (len + 2)
                  send_word(plain(ttyld_pkg::CMD_READ, 8'($urandom_range(0, 255))));
               done += 2 * len + 3;
            end else begin
               pick = $urandom_range(0, 9);
               if (pick <= 3)
                  send_word(plain(ttyld_pkg::CMD_RX, pick_byte()));
               else if (pick <= 6)
                  send_word(plain(ttyld_pkg::CMD_TX, pick_byte()));
               else if (pick <= 8)
                  send_word(plain(ttyld_pkg::CMD_READ, 8'($urandom_range(0, 255))));
               else
                  send_word(plain(ttyld_pkg::CMD_NONE, 8'($urandom_range(0, 255))));
               if (pick <= 8) done++;
            end
         end
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      waited = 0;
      while (out_words_due.size() != 0 && waited < END_WAIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE) @(negedge clock);
      if (out_words_due.size() != 0) begin
         fails++;
         $display("%0t: %0d words never arrived, next expected kind %0d byte %02h",
                  $time, out_words_due.size(), out_words_due[0].kind,
                  out_words_due[0].byte_out);
      end
      if (fails == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
